[hw/rtl/dmr_pkg.sv]
// Shared types and constants of the dense matrix-vector residual engine.
package dmr_pkg;

  // Largest supported order by default, and the hard cap on the vector store.
  localparam int MAX_ORDER_DEF = 64;
  localparam int XCAP          = 64;

  // Order in use after reset.
  localparam logic [6:0] SIZE_RESET = 7'd64;

  // Entries of the command queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Item kinds.
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_ELEM  = 2'd1;
  localparam logic [1:0] FUNC_CLOSE = 2'd2;

  // Command handed from the front to the back.
  typedef struct packed {
    logic        is_close;
    logic        acc_en;
    logic [31:0] value;
    logic [31:0] xval;
    logic [5:0]  row_number;
    logic        mismatch;
    logic        last_row;
  } cmd_t;

endpackage

[hw/rtl/dmr_front.sv]
// Front end: accepts items, holds the x store and the row and column counters.
module dmr_front #(
  parameter int MAX_ORDER = dmr_pkg::MAX_ORDER_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_func,
  input  logic [5:0]        in_index,
  input  logic [31:0]       in_value,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_wdata,
  input  logic              q_full,
  output logic              q_push,
  output dmr_pkg::cmd_t     q_cmd
);

  localparam int XDEPTH = (MAX_ORDER < dmr_pkg::XCAP) ? MAX_ORDER : dmr_pkg::XCAP;
  localparam int AW     = $clog2(XDEPTH);
  localparam logic [6:0] CAP_N = 7'(XDEPTH);

  logic [31:0] xmem [XDEPTH];
  logic [31:0] xrd_r;

  logic [6:0]  size_r;
  logic [6:0]  col_r, col_nxt;
  logic [5:0]  row_r, row_nxt;
  logic        f_valid_r, f_valid_nxt;

  logic        f_close_r;
  logic        f_acc_en_r;
  logic [31:0] f_value_r;
  logic [5:0]  f_row_r;
  logic        f_mis_r;
  logic        f_last_r;

  logic [6:0]  n;
  logic        accept;
  logic        is_load, is_elem, is_close;
  logic        col_ok, idx_ok;
  logic [6:0]  row_inc;

  // Effective order, clamped to the supported range.
  always_comb begin
    if (size_r == 7'd0) begin
      n = 7'd1;
    end else if (size_r > CAP_N) begin
      n = CAP_N;
    end else begin
      n = size_r;
    end
  end

  // Classify the incoming item.
  always_comb begin
    is_load  = 1'b0;
    is_elem  = 1'b0;
    is_close = 1'b0;
    case (in_func)
      dmr_pkg::FUNC_LOAD:  is_load  = 1'b1;
      dmr_pkg::FUNC_ELEM:  is_elem  = 1'b1;
      dmr_pkg::FUNC_CLOSE: is_close = 1'b1;
      default: ;
    endcase
  end

  assign q_push   = f_valid_r && !q_full;
  assign in_stall = f_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign col_ok   = col_r < n;
  assign idx_ok   = {1'b0, in_index} < CAP_N;
  assign row_inc  = {1'b0, row_r} + 7'd1;

  // Counter and stage updates.
  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    f_valid_nxt = q_push ? 1'b0 : f_valid_r;
    if (accept && is_elem) begin
      if (col_r != 7'd127) begin
        col_nxt = col_r + 7'd1;
      end
      f_valid_nxt = 1'b1;
    end
    if (accept && is_close) begin
      col_nxt     = 7'd0;
      row_nxt     = (row_inc >= n) ? 6'd0 : row_inc[5:0];
      f_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r    <= dmr_pkg::SIZE_RESET;
      col_r     <= 7'd0;
      row_r     <= 6'd0;
      f_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      f_valid_r <= f_valid_nxt;
    end
  end

  // Stage register payload, captured with the item.
  always_ff @(posedge clk) begin
    if (accept && (is_elem || is_close)) begin
      f_close_r  <= is_close;
      f_acc_en_r <= is_elem && col_ok;
      f_value_r  <= in_value;
      f_row_r    <= row_r;
      f_mis_r    <= col_r != n;
      f_last_r   <= {1'b0, row_r} == (n - 7'd1);
    end
  end

  // Vector store: written by loads, read at the column counter for elements.
  always_ff @(posedge clk) begin
    if (accept && is_load && idx_ok) begin
      xmem[in_index[AW-1:0]] <= in_value;
    end
    if (accept && is_elem && col_ok) begin
      xrd_r <= xmem[col_r[AW-1:0]];
    end
  end

  always_comb begin
    q_cmd.is_close   = f_close_r;
    q_cmd.acc_en     = f_acc_en_r;
    q_cmd.value      = f_value_r;
    q_cmd.xval       = xrd_r;
    q_cmd.row_number = f_row_r;
    q_cmd.mismatch   = f_mis_r;
    q_cmd.last_row   = f_last_r;
  end

endmodule

[hw/rtl/dmr_queue.sv]
// Short command queue that decouples the front end from the arithmetic back end.
module dmr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dmr_pkg::cmd_t     push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output dmr_pkg::cmd_t     head
);

  localparam int DEPTH = dmr_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  dmr_pkg::cmd_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full  = cnt_r == FULL_CNT;
  assign empty = cnt_r == '0;
  assign head  = mem[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[hw/rtl/dmr_back.sv]
// Back end: multiply, saturating accumulate, row close and result register.
module dmr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  dmr_pkg::cmd_t     q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [5:0]        out_row_number,
  output logic [31:0]       out_residual_value,
  output logic              out_saturated,
  output logic              out_count_mismatch,
  output logic              out_last_row
);

  localparam logic signed [63:0] ACC_LIM  = 64'sh4000_0000_0000_0000;
  localparam logic signed [63:0] ACC_NLIM = -ACC_LIM;
  localparam logic signed [63:0] ACC_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ACC_MIN  = 64'sh8000_0000_0000_0000;
  localparam logic signed [64:0] R_MAX    = 65'sd2147483647;
  localparam logic signed [64:0] R_MIN    = -65'sd2147483648;
  localparam logic signed [64:0] HALF_LSB = 65'sd32768;

  logic adv;

  // Multiply stage.
  logic               s1_valid_r;
  logic               s1_close_r;
  logic               s1_acc_en_r;
  logic signed [63:0] s1_prod_r;
  logic [31:0]        s1_b_r;
  logic [5:0]         s1_row_r;
  logic               s1_mis_r;
  logic               s1_last_r;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;

  // Accumulator and close stage.
  logic signed [63:0] acc_r, acc_nxt;
  logic               clip_r, clip_nxt;
  logic               s2_valid_r;
  logic signed [64:0] s2_diff_r;
  logic               s2_fmin_r;
  logic               s2_fmax_r;
  logic               s2_sat_r;
  logic [5:0]         s2_row_r;
  logic               s2_mis_r;
  logic               s2_last_r;
  logic signed [64:0] sum;
  logic signed [64:0] b_wide;
  logic signed [64:0] diff;

  // Rounding and result saturation.
  logic               out_valid_r;
  logic signed [64:0] rnd;
  logic signed [64:0] rq;
  logic [31:0]        res;
  logic               res_sat;

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_empty;

  assign mul_a = q_head.value;
  assign mul_b = q_head.xval;
  assign prod  = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (adv && !q_empty) begin
      s1_close_r  <= q_head.is_close;
      s1_acc_en_r <= q_head.acc_en;
      s1_prod_r   <= prod;
      s1_b_r      <= q_head.value;
      s1_row_r    <= q_head.row_number;
      s1_mis_r    <= q_head.mismatch;
      s1_last_r   <= q_head.last_row;
    end
  end

  // Saturating accumulate for elements; clear after a close.
  assign sum    = {acc_r[63], acc_r} + {s1_prod_r[63], s1_prod_r};
  assign b_wide = {{17{s1_b_r[31]}}, s1_b_r, 16'h0000};
  assign diff   = b_wide - {acc_r[63], acc_r};

  always_comb begin
    acc_nxt  = acc_r;
    clip_nxt = clip_r;
    if (adv && s1_valid_r) begin
      if (s1_close_r) begin
        acc_nxt  = '0;
        clip_nxt = 1'b0;
      end else if (s1_acc_en_r) begin
        if (sum[64] != sum[63]) begin
          acc_nxt  = sum[64] ? ACC_MIN : ACC_MAX;
          clip_nxt = 1'b1;
        end else begin
          acc_nxt = sum[63:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r && s1_close_r) begin
      s2_diff_r <= diff;
      s2_fmin_r <= acc_r > ACC_LIM;
      s2_fmax_r <= acc_r < ACC_NLIM;
      s2_sat_r  <= clip_r;
      s2_row_r  <= s1_row_r;
      s2_mis_r  <= s1_mis_r;
      s2_last_r <= s1_last_r;
    end
  end

  // Round half up to Q16.16 and clip to 32 bits.
  assign rnd = s2_diff_r + HALF_LSB;
  assign rq  = rnd >>> 16;

  always_comb begin
    res     = rq[31:0];
    res_sat = s2_sat_r;
    if (s2_fmin_r) begin
      res     = R_MIN[31:0];
      res_sat = 1'b1;
    end else if (s2_fmax_r) begin
      res     = R_MAX[31:0];
      res_sat = 1'b1;
    end else if (rq > R_MAX) begin
      res     = R_MAX[31:0];
      res_sat = 1'b1;
    end else if (rq < R_MIN) begin
      res     = R_MIN[31:0];
      res_sat = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r) begin
      out_row_number     <= s2_row_r;
      out_residual_value <= res;
      out_saturated      <= res_sat;
      out_count_mismatch <= s2_mis_r;
      out_last_row       <= s2_last_r;
    end
  end

  // Control state of the back pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      clip_r      <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      clip_r <= clip_nxt;
      if (adv) begin
        s1_valid_r  <= !q_empty;
        s2_valid_r  <= s1_valid_r && s1_close_r;
        out_valid_r <= s2_valid_r;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

[hw/rtl/dense_matvec_residual.sv]
// Top level of the dense residual engine r = b - A*x.
//
// Input channel (in_valid, in_stall, in_func, in_index, in_value): an item is
// taken at a clock edge with in_valid high and in_stall low. Kind 0 loads one
// entry of x, kind 1 is one matrix element in row-major order, and kind 2
// carries b for the current row and closes it. Kind 3 is dropped.
// Result channel (out_valid, out_stall, out_*): one result per closing item,
// held steady while out_stall is high.
// Configuration: cfg_we writes cfg_wdata into the order register at once;
// write it only while the block is idle.
// Throughput: one item per cycle while in_stall is low. The front end reads the x store at the
// column counter, a four-entry queue hands the item to the back end, and the
// back end runs multiply, then saturating accumulate and close, then rounding
// as one stage each; the accumulator register feeds its own adder directly.
// A closing item passes the front stage register, the queue, the multiply
// stage and the close stage before its result is registered onto out_valid.
// A stalled result freezes the back end; the front keeps taking items until
// the queue fills, then raises in_stall.
// Reset (rst_n low at a clock edge) clears the counters, the accumulator and
// the queue, and sets the order to 64. The x store is not cleared.
module dense_matvec_residual #(
  parameter int MAX_ORDER = dmr_pkg::MAX_ORDER_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [5:0]  in_index,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_row_number,
  output logic [31:0] out_residual_value,
  output logic        out_saturated,
  output logic        out_count_mismatch,
  output logic        out_last_row,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);

  logic          q_push, q_full, q_pop, q_empty;
  dmr_pkg::cmd_t q_in, q_head;

  // Front end: classification, counters and the x store.
  dmr_front #(
    .MAX_ORDER (MAX_ORDER)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_func),
    .in_index  (in_index),
    .in_value  (in_value),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_in)
  );

  // Queue between the two halves.
  dmr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // Back end: arithmetic and result register.
  dmr_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_row_number     (out_row_number),
    .out_residual_value (out_residual_value),
    .out_saturated      (out_saturated),
    .out_count_mismatch (out_count_mismatch),
    .out_last_row       (out_last_row)
  );

endmodule

[bench/dmr_residual_checker.sv]
`timescale 1ns / 100ps
// Checker for the dense residual engine: predicts each residual entry and compares results.
module dmr_residual_checker #(
  parameter int MAX_ORDER = dmr_pkg::MAX_ORDER_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [5:0]  in_index,
  input  logic [31:0] in_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [5:0]  out_row_number,
  input  logic [31:0] out_residual_value,
  input  logic        out_saturated,
  input  logic        out_count_mismatch,
  input  logic        out_last_row,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  output int          fail_count,
  output int          pending_results
);

  localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] ACC_MIN = {1'b1, {63{1'b0}}};
  localparam longint             ACC_LIM = 64'sh4000_0000_0000_0000;
  localparam longint             Q_MAX   = 64'sd2147483647;
  localparam longint             Q_MIN   = -64'sd2147483648;

  typedef struct packed {
    logic [5:0]  row;
    logic [31:0] value;
    logic        sat;
    logic        mismatch;
    logic        last;
  } residual_t;

  // Local copy of the engine state.
  logic signed [31:0] x_vec [MAX_ORDER];
  logic signed [63:0] dot_acc;
  logic [6:0]         col_count;
  logic [5:0]         row_count;
  logic               clip;
  logic [6:0]         order_reg;

  residual_t expected_residuals[$];
  int errors = 0;

  assign fail_count      = errors;
  assign pending_results = expected_residuals.size();

  task automatic report_error(input string msg);
    begin
      $display("ERROR at %0t ns: %s", $time, msg);
      errors++;
    end
  endtask

  // The order register clamped to the supported range.
  function automatic int unsigned effective_order();
    int unsigned cap;
    int unsigned n;
    begin
      cap = (MAX_ORDER < 64) ? MAX_ORDER : 64;
      n = order_reg;
      if (n < 1) n = 1;
      if (n > cap) n = cap;
      return n;
    end
  endfunction

  // Applies one accepted item to the local state and queues a residual on a row close.
  task automatic advance_residual_state(input logic [1:0] func, input logic [5:0] idx,
                                        input logic [31:0] raw);
    logic signed [31:0] v;
    longint             prod;
    logic [64:0]        sum;
    longint             diff;
    longint             r;
    int unsigned        n;
    residual_t          res;
    begin
      v = raw;
      n = effective_order();
      case (func)
        dmr_pkg::FUNC_LOAD: begin
          if (idx < MAX_ORDER) x_vec[idx] = v;
        end
        dmr_pkg::FUNC_ELEM: begin
          if (col_count < n && col_count < MAX_ORDER) begin
            prod = longint'(v) * longint'(x_vec[col_count]);
            sum = {dot_acc[63], dot_acc} + {prod[63], prod};
            // A carry into the extra bit that disagrees with bit 63 means overflow.
            if (sum[64] != sum[63]) begin
              dot_acc = sum[64] ? ACC_MIN : ACC_MAX;
              clip = 1'b1;
            end else begin
              dot_acc = sum[63:0];
            end
          end
          if (col_count < 7'd127) col_count++;
        end
        dmr_pkg::FUNC_CLOSE: begin
          res.sat = clip;
          if (dot_acc > ACC_LIM) begin
            r = Q_MIN;
            res.sat = 1'b1;
          end else if (dot_acc < -ACC_LIM) begin
            r = Q_MAX;
            res.sat = 1'b1;
          end else begin
            // Widen b to Q32.32, subtract, round half up back to Q16.16.
            diff = (longint'(v) <<< 16) - dot_acc;
            r = (diff + 64'sd32768) >>> 16;
            if (r > Q_MAX) begin
              r = Q_MAX;
              res.sat = 1'b1;
            end else if (r < Q_MIN) begin
              r = Q_MIN;
              res.sat = 1'b1;
            end
          end
          res.row      = row_count;
          res.value    = r[31:0];
          res.mismatch = (col_count != n);
          res.last     = (row_count == n - 1);
          expected_residuals.push_back(res);
          row_count = (row_count + 1 >= n) ? 6'd0 : row_count + 6'd1;
          dot_acc   = '0;
          col_count = '0;
          clip      = 1'b0;
        end
        default: begin
        end
      endcase
    end
  endtask

  // Compares one accepted result with the oldest queued residual.
  task automatic check_residual();
    residual_t want;
    begin
      if (expected_residuals.size() == 0) begin
        report_error($sformatf("result for row %0d with no item waiting", out_row_number));
      end else begin
        want = expected_residuals.pop_front();
        if (out_row_number !== want.row)
          report_error($sformatf("row_number got %0d want %0d", out_row_number, want.row));
        if (out_residual_value !== want.value)
          report_error($sformatf("row %0d residual_value got %h want %h",
                                 want.row, out_residual_value, want.value));
        if (out_saturated !== want.sat)
          report_error($sformatf("row %0d saturated got %b want %b",
                                 want.row, out_saturated, want.sat));
        if (out_count_mismatch !== want.mismatch)
          report_error($sformatf("row %0d count_mismatch got %b want %b",
                                 want.row, out_count_mismatch, want.mismatch));
        if (out_last_row !== want.last)
          report_error($sformatf("row %0d last_row got %b want %b",
                                 want.row, out_last_row, want.last));
      end
    end
  endtask

  // Watch all three ports at each rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      dot_acc   = '0;
      col_count = '0;
      row_count = '0;
      clip      = 1'b0;
      order_reg = dmr_pkg::SIZE_RESET;
      expected_residuals.delete();
    end else begin
      if (out_valid && !out_stall) check_residual();
      if (cfg_we) order_reg = cfg_wdata;
      if (in_valid && !in_stall) advance_residual_state(in_func, in_index, in_value);
    end
  end

endmodule

[bench/tb_dense_matvec_residual.sv]
`timescale 1ns / 100ps
// Testbench top for the dense residual engine: stimulus, idling and the verdict.
module tb_dense_matvec_residual;

  localparam logic [1:0] FUNC_SPARE  = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         ITEM_TARGET = 520;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_func;
  logic [5:0]  in_index;
  logic [31:0] in_value;
  logic        out_valid;
  logic        out_stall;
  logic [5:0]  out_row_number;
  logic [31:0] out_residual_value;
  logic        out_saturated;
  logic        out_count_mismatch;
  logic        out_last_row;
  logic        cfg_we;
  logic [6:0]  cfg_wdata;

  int fail_count;
  int pending_results;

  int          accepted_items = 0;
  int          cur_order = 64;
  bit          no_idle = 1'b0;
  bit          x_written [64];
  int unsigned cycle_count = 0;
  int          stall_left = 0;

  dense_matvec_residual i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_index           (in_index),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_row_number     (out_row_number),
    .out_residual_value (out_residual_value),
    .out_saturated      (out_saturated),
    .out_count_mismatch (out_count_mismatch),
    .out_last_row       (out_last_row),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  dmr_residual_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_index           (in_index),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_row_number     (out_row_number),
    .out_residual_value (out_residual_value),
    .out_saturated      (out_saturated),
    .out_count_mismatch (out_count_mismatch),
    .out_last_row       (out_last_row),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .fail_count         (fail_count),
    .pending_results    (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    begin
      return no_idle ? 0 : $urandom_range(0, 3);
    end
  endfunction

  // Operand mix: extremes, small values near one and full-range noise.
  function automatic logic [31:0] rand_q();
    begin
      case ($urandom_range(0, 9))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2, 3: return $urandom_range(0, 262143) - 131072;
        4: return $urandom_range(0, 2) - 1;
        default: return $urandom();
      endcase
    end
  endfunction

  // Result side: after each taken result, stall for a drawn number of cycles.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) stall_left = pick_gap();
      else if (stall_left > 0) stall_left--;
      @(negedge clk);
      out_stall = (stall_left > 0);
    end
  end

  // Drives one item after a drawn gap and holds it until the block takes it.
  task automatic send_item(input logic [1:0] f, input logic [5:0] ix, input logic [31:0] v);
    int gap;
    begin
      gap = pick_gap();
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid = 1'b1;
      in_func  = f;
      in_index = ix;
      in_value = v;
      do @(posedge clk); while (in_stall);
      @(negedge clk);
      if (f != FUNC_SPARE) accepted_items++;
    end
  endtask

  task automatic load_x(input int ix, input logic [31:0] v);
    begin
      x_written[ix] = 1'b1;
      send_item(dmr_pkg::FUNC_LOAD, 6'(ix), v);
    end
  endtask

  // Every x entry the current order can read must hold a written value.
  task automatic ensure_x();
    begin
      for (int i = 0; i < cur_order; i++)
        if (!x_written[i]) load_x(i, rand_q());
    end
  endtask

  // Matrix elements of one row, with stray loads and spare kinds mixed in.
  task automatic send_elems(input int count);
    int pick;
    begin
      for (int i = 0; i < count; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) load_x($urandom_range(0, 63), rand_q());
        else if (pick < 12) send_item(FUNC_SPARE, 6'($urandom()), $urandom());
        send_item(dmr_pkg::FUNC_ELEM, 6'($urandom()), rand_q());
      end
    end
  endtask

  task automatic send_row(input int count);
    begin
      ensure_x();
      send_elems(count);
      send_item(dmr_pkg::FUNC_CLOSE, 6'($urandom()), rand_q());
    end
  endtask

  // Wait for every result, then for items without results to leave the pipeline.
  task automatic quiesce();
    begin
      in_valid = 1'b0;
      while (pending_results != 0) @(negedge clk);
      repeat (12) @(negedge clk);
    end
  endtask

  task automatic write_order(input logic [6:0] v);
    begin
      cfg_we    = 1'b1;
      cfg_wdata = v;
      @(negedge clk);
      cfg_we    = 1'b0;
      cur_order = (v < 1) ? 1 : ((v > 64) ? 64 : v);
    end
  endtask

  initial begin
    int sel;
    int rows;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_func   = dmr_pkg::FUNC_LOAD;
    in_index  = '0;
    in_value  = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed rows at order 3.
    write_order(7'd3);
    load_x(0, 32'h8000_0000);
    load_x(1, 32'h8000_0000);
    load_x(2, 32'h8000_0000);
    // Three products of 2^62 overflow the accumulator upward.
    repeat (3) send_item(dmr_pkg::FUNC_ELEM, 6'd0, 32'h8000_0000);
    send_item(dmr_pkg::FUNC_CLOSE, 6'd0, 32'h0001_0000);
    load_x(1, 32'h7FFF_FFFF);
    load_x(2, 32'h0001_0000);
    // Large negative sum without overflow: the result clips to the top.
    send_item(dmr_pkg::FUNC_ELEM, 6'd0, 32'h7FFF_FFFF);
    send_item(dmr_pkg::FUNC_ELEM, 6'd0, 32'h8000_0000);
    send_item(dmr_pkg::FUNC_ELEM, 6'd0, 32'h0000_8000);
    send_item(dmr_pkg::FUNC_CLOSE, 6'd0, 32'h7FFF_FFFF);
    send_item(FUNC_SPARE, 6'd63, 32'hFFFF_FFFF);
    // Short last row.
    send_item(dmr_pkg::FUNC_ELEM, 6'd0, 32'h0000_0000);
    send_item(dmr_pkg::FUNC_CLOSE, 6'd0, 32'hFFFF_FFFF);
    load_x(0, 32'h0000_0001);
    load_x(63, 32'h7FFF_FFFF);
    // A half-way tie that rounds up to zero, plus one extra element.
    send_item(dmr_pkg::FUNC_ELEM, 6'd0, 32'h0000_8000);
    send_item(dmr_pkg::FUNC_ELEM, 6'd0, 32'h0000_0000);
    send_item(dmr_pkg::FUNC_ELEM, 6'd0, 32'h0000_0000);
    send_item(dmr_pkg::FUNC_ELEM, 6'd0, 32'h8000_0000);
    send_item(dmr_pkg::FUNC_CLOSE, 6'd0, 32'h0000_0000);
    // Moderate accumulators where only the rounded result clips, both signs.
    send_item(dmr_pkg::FUNC_ELEM, 6'd0, 32'h0000_0000);
    send_item(dmr_pkg::FUNC_ELEM, 6'd0, 32'h0000_0000);
    send_item(dmr_pkg::FUNC_ELEM, 6'd0, 32'h8000_0000);
    send_item(dmr_pkg::FUNC_CLOSE, 6'd0, 32'h7FFF_FFFF);
    send_item(dmr_pkg::FUNC_ELEM, 6'd0, 32'h0000_0000);
    send_item(dmr_pkg::FUNC_ELEM, 6'd0, 32'h0000_0000);
    send_item(dmr_pkg::FUNC_ELEM, 6'd0, 32'h7FFF_FFFF);
    send_item(dmr_pkg::FUNC_CLOSE, 6'd0, 32'h8000_0000);

    // Order zero clamps to one; a long row drives the column count to its ceiling.
    quiesce();
    write_order(7'd0);
    send_row(130);

    // Order above the store clamps to 64: one full row.
    quiesce();
    write_order(7'd127);
    send_row(64);

    // Random phases, each with its own order and idling style.
    while (accepted_items < ITEM_TARGET) begin
      quiesce();
      sel = $urandom_range(0, 9);
      case (sel)
        0: write_order(7'd0);
        1: write_order(7'd127);
        2: write_order(7'd64);
        3: write_order(7'($urandom_range(65, 126)));
        4: write_order(7'($urandom_range(9, 24)));
        default: write_order(7'($urandom_range(1, 8)));
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      rows = (cur_order >= 20) ? $urandom_range(1, 2) : $urandom_range(1, 2 * cur_order + 2);
      for (int r = 0; r < rows; r++) begin
        if ($urandom_range(0, 99) < 80) send_row(cur_order);
        else send_row($urandom_range(0, cur_order + 3));
      end
      // Sometimes leave a row open across the next order change.
      if ($urandom_range(0, 99) < 15) begin
        ensure_x();
        send_elems($urandom_range(1, cur_order));
      end
    end
    no_idle = 1'b0;

    quiesce();
    if (fail_count == 0 && pending_results == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
